### sv/nfa_byte_matcher_top_assert.svh
// Assertion macros for the byte matcher.
`ifndef NFA_BYTE_MATCHER_TOP_ASSERT_SVH
`define NFA_BYTE_MATCHER_TOP_ASSERT_SVH

`ifndef SYNTH
`define NBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nbm assertion failed");
`define NBM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("nbm reset assertion failed");
`else
`define NBM_ASSERT(lbl, prop)
`define NBM_ASSERT_RST(lbl, prop)
`endif

`endif

### sv/nbm_pkg.sv
package nbm_pkg;

  localparam int NUM_STATES  = 64;
  localparam int MAX_LEN     = 1024;
  localparam int BYTE_VALUES = 256;

  localparam int KIND_W  = 2;
  localparam int STATE_W = 6;
  localparam int SYM_W   = 8;
  localparam int SET_W   = NUM_STATES;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = STATE_W + SYM_W;
  localparam int DEPTH   = NUM_STATES * BYTE_VALUES;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SYM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   symbol;
  } item_t;

  typedef struct packed {
    logic               start_wr;
    logic [STATE_W-1:0] start_new;
    logic [STATE_W-1:0] start;
    logic [SET_W-1:0]   accept;
  } cfg_t;

  typedef struct packed {
    logic             matched;
    logic [CNT_W-1:0] length_used;
  } res_t;

  typedef struct packed {
    logic             clearing;
    logic             idle;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage

### sv/nbm_ram.sv
module nbm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/nbm_engine.sv
module nbm_engine import nbm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  cfg_t  cfg_i,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o,
  output sts_t  sts_o
);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_LOAD_RD  = 3'd2;
  localparam logic [2:0] ST_LOAD_WR  = 3'd3;
  localparam logic [2:0] ST_SCAN     = 3'd4;
  localparam logic [2:0] ST_SCAN_END = 3'd5;
  localparam logic [2:0] ST_END      = 3'd6;

  logic [2:0]         state_q, state_d;
  item_t              item_q, item_d;
  logic [STATE_W-1:0] scan_q, scan_d;
  logic               hit_q, hit_d;
  logic [SET_W-1:0]   acc_q, acc_d;
  logic [SET_W-1:0]   active_q, active_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [SET_W-1:0]  wdata, rdata;
  logic [SET_W-1:0]  row_hit;

  nbm_ram #(
    .WIDTH(SET_W),
    .DEPTH(DEPTH)
  ) u_trans (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // row returned this cycle counts only if its source state was active
  assign row_hit = hit_q ? rdata : '0;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    scan_d      = scan_q;
    hit_d       = 1'b0;
    acc_d       = acc_q | row_hit;
    active_d    = active_q;
    count_d     = count_q;
    clr_d       = clr_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = {item_q.from_state, item_q.symbol};
    raddr       = {item_q.from_state, item_q.symbol};
    wdata       = rdata | (SET_W'(1) << item_q.to_state);
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_item_i;
          unique case (in_item_i.kind)
            KIND_LOAD: state_d = ST_LOAD_RD;
            KIND_SYM: begin
              if (count_q < CNT_W'(MAX_LEN)) begin
                scan_d  = '0;
                acc_d   = '0;
                state_d = ST_SCAN;
              end
            end
            KIND_END: state_d = ST_END;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD_RD: begin
        re      = 1'b1;
        state_d = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        we      = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        re     = 1'b1;
        raddr  = {scan_q, item_q.symbol};
        hit_d  = active_q[scan_q];
        scan_d = scan_q + STATE_W'(1);
        if (scan_q == STATE_W'(NUM_STATES - 1)) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        active_d = acc_q | row_hit;
        count_d  = count_q + CNT_W'(1);
        state_d  = ST_IDLE;
      end
      ST_END: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          active_d = SET_W'(1) << cfg_i.start;
          count_d  = '0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // writing the start state restarts the current string
    if (cfg_i.start_wr) begin
      active_d = SET_W'(1) << cfg_i.start_new;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      scan_q   <= '0;
      hit_q    <= 1'b0;
      active_q <= SET_W'(1);
      count_q  <= '0;
      clr_q    <= '0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      hit_q    <= hit_d;
      active_q <= active_d;
      count_q  <= count_d;
      clr_q    <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    acc_q  <= acc_d;
  end

  assign res_o.matched     = |(active_q & cfg_i.accept);
  assign res_o.length_used = count_q;

  assign sts_o.clearing = (state_q == ST_CLEAR);
  assign sts_o.idle     = (state_q == ST_IDLE);
  assign sts_o.count    = count_q;

endmodule

### sv/nfa_byte_matcher_top.sv
// Byte-wise NFA matcher with a 64-state x 256-byte successor memory.
// Input stream: tuser carries the item kind (load transition, symbol, end of
// string); tdata carries from_state, to_state and the byte. Output stream
// gives one beat per end item: the match flag and the symbol count.
// Config port: index 0 writes start_state (restarts the current string),
// index 1 writes accept_mask; one write per cycle, no read-back.
// Work per item, from the accepting edge until ready again:
//   load   read-modify-write of one memory row
//   symbol one memory read per state, 64 states, then the set update;
//          a symbol past the length limit is taken and dropped
//   end    result handoff, longer while the output beat is still held by the receiver.
// The output beat of an end item is registered once the engine is in its end
// state and the output register is free.
// Symbol rate is set by the single read port of the successor memory.
// After reset the memory is cleared one row a cycle, all 16384 rows, with
// tready low. Config writes are taken during that pass.
// A stalled output beat holds; further load and symbol items are still taken,
// and a new end item waits until the output register frees up.
module nfa_byte_matcher_top import nbm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [5:0] from_state, [11:6] to_state, [19:12] symbol, [23:20] zero
  input  logic [23:0]           s_axis_tdata_i,
  // [1:0] kind
  input  logic [KIND_W-1:0]     s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [0] matched, [11:1] length_used, [15:12] zero
  output logic [15:0]           m_axis_tdata_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  `include "nfa_byte_matcher_top_assert.svh"

  logic [STATE_W-1:0] start_q;
  logic [SET_W-1:0]   accept_q;
  logic               out_valid_q;
  res_t               out_q;

  item_t item;
  cfg_t  cfg;
  res_t  res;
  sts_t  sts;
  logic  res_valid, res_ready;

  assign item.kind       = s_axis_tuser_i;
  assign item.from_state = s_axis_tdata_i[5:0];
  assign item.to_state   = s_axis_tdata_i[11:6];
  assign item.symbol     = s_axis_tdata_i[19:12];

  assign cfg.start_wr  = cfg_we_i && (cfg_idx_i == CFG_START);
  assign cfg.start_new = cfg_data_i[STATE_W-1:0];
  assign cfg.start     = start_q;
  assign cfg.accept    = accept_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      accept_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START:  start_q  <= cfg_data_i[STATE_W-1:0];
        CFG_ACCEPT: accept_q <= cfg_data_i[SET_W-1:0];
        default: ;
      endcase
    end
  end

  nbm_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (item),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .sts_o      (sts)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_q.length_used, out_q.matched};

  `NBM_ASSERT(a_no_accept_clr, sts.clearing |-> !s_axis_tready_o)
  `NBM_ASSERT(a_ready_idle, s_axis_tready_o == sts.idle)
  `NBM_ASSERT(a_len_bound, m_axis_tvalid_o |-> (out_q.length_used <= CNT_W'(MAX_LEN)))
  `NBM_ASSERT(a_start_restart, cfg.start_wr |=> (sts.count == '0))
  `NBM_ASSERT_RST(a_rst_out, !rst_ni |-> !m_axis_tvalid_o)

endmodule
